>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the key/value cache checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside of reset.
`define LRUKV_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The condition must never be seen at a clock edge outside of reset.
`define LRUKV_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> hw/rtl/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Transaction payload types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  localparam int unsigned KeyW = 16;
  localparam int unsigned ValW = 32;
  localparam int unsigned CfgW = 5;

  localparam logic ModeGet = 1'b0;
  localparam logic ModePut = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [KeyW-1:0]        key;
    logic signed [ValW-1:0] value;
  } in_t;

  typedef struct packed {
    logic                   found;
    logic signed [ValW-1:0] read_value;
    logic                   evicted;
    logic [KeyW-1:0]        evicted_key;
  } out_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic eval_search;
    logic eval_update;
    logic decide;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hw/rtl/lru_key_value_cache_unit.sv
// A new transaction is accepted only after the last one has finished. The pace is
// set by the single read port of the entry memories, which the search pass and
// the rank update pass each sweep one entry per cycle. The output register holds
// a result while the next one runs.
// Reset: asynchronous, active low; clears control, all valid bits and occupancy,
// and sets capacity to ENTRIES. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
// LRU key/value cache top level
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lrukv_pkg::in_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lrukv_pkg::out_t            out_data_o,
  input  logic                       cfg_we_i,
  input  logic [lrukv_pkg::CfgW-1:0] cfg_wdata_i
);
  import lrukv_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  lrukv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrukv_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> hw/rtl/lrukv_ctrl.sv
// ----------------------------------------------------------------------------
// LRU key/value cache controller
// Sequences the search pass, the decision and the recency update pass.
// ----------------------------------------------------------------------------
module lrukv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrukv_pkg::dp_sts_t sts_i,
  output lrukv_pkg::dp_cmd_t cmd_o
);
  import lrukv_pkg::*;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StSearch = 7'b0000010,
    StSDrain = 7'b0000100,
    StDecide = 7'b0001000,
    StUpdate = 7'b0010000,
    StUDrain = 7'b0100000,
    StDone   = 7'b1000000
  } ctl_state_e;

  ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSearch;
        end
      end
      StSearch: begin
        cmd_o.issue       = 1'b1;
        cmd_o.eval_search = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StSDrain;
        end
      end
      StSDrain: begin
        cmd_o.eval_search = 1'b1;
        state_d           = StDecide;
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d      = StUpdate;
      end
      StUpdate: begin
        cmd_o.issue       = 1'b1;
        cmd_o.eval_update = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StUDrain;
        end
      end
      StUDrain: begin
        cmd_o.eval_update = 1'b1;
        state_d           = StDone;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

>>> hw/rtl/lrukv_dpath.sv
// ----------------------------------------------------------------------------
// LRU key/value cache datapath
// Entry memories, valid bits, search trackers, rank update and output register.
// ----------------------------------------------------------------------------
module lrukv_dpath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lrukv_pkg::in_t            in_data_i,
  input  logic                      cfg_we_i,
  input  logic [lrukv_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output lrukv_pkg::out_t           out_data_o,
  input  lrukv_pkg::dp_cmd_t        cmd_i,
  output lrukv_pkg::dp_sts_t        sts_o
);
  import lrukv_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OccW = $clog2(ENTRIES + 1);

  function automatic logic [OccW-1:0] clamp_cap(logic [CfgW-1:0] v);
    logic [OccW-1:0] c;
    if (v == '0) begin
      c = OccW'(1);
    end else if (32'(v) > ENTRIES) begin
      c = OccW'(ENTRIES);
    end else begin
      c = OccW'(v);
    end
    return c;
  endfunction

  logic [KeyW-1:0] key_mem  [ENTRIES];
  logic [ValW-1:0] val_mem  [ENTRIES];
  logic [IdxW-1:0] rank_mem [ENTRIES];

  logic [ENTRIES-1:0] valid_q;
  logic [OccW-1:0]    occ_q, cap_q;
  in_t                req_q;
  logic [IdxW-1:0]    scan_q;

  logic            rd_live_q, rd_vld_q;
  logic [IdxW-1:0] rd_idx_q, rd_rank_q;
  logic [KeyW-1:0] rd_key_q;
  logic [ValW-1:0] rd_val_q;

  logic            hit_q, free_q, lru_q;
  logic [IdxW-1:0] hit_idx_q, hit_rank_q, free_idx_q, lru_idx_q, lru_rank_q;
  logic [ValW-1:0] hit_val_q;
  logic [KeyW-1:0] lru_key_q;

  logic [IdxW-1:0] tgt_q;
  logic [OccW-1:0] old_q;
  out_t            res_q;
  logic            out_valid_q;
  out_t            out_q;

  logic            s_ev, is_hit, is_free, is_lru, upd_we;
  logic            dec_key_we, dec_val_we, dec_rank_we, dec_alloc;
  logic [IdxW-1:0] dec_tgt;
  logic [OccW-1:0] dec_old;
  out_t            dec_res;
  logic            rank_we;
  logic [IdxW-1:0] rank_wa, rank_wd;

  assign sts_o.scan_last = (scan_q == IdxW'(ENTRIES - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  assign s_ev    = cmd_i.eval_search && rd_live_q;
  assign is_hit  = s_ev && rd_vld_q && (rd_key_q == req_q.key) && !hit_q;
  assign is_free = s_ev && !rd_vld_q && !free_q;
  assign is_lru  = s_ev && rd_vld_q && (!lru_q || (rd_rank_q > lru_rank_q));

  assign upd_we = cmd_i.eval_update && rd_live_q && rd_vld_q && (rd_idx_q != tgt_q)
                  && (OccW'(rd_rank_q) < old_q);

  always_comb begin
    dec_res     = '0;
    dec_old     = '0;
    dec_tgt     = hit_idx_q;
    dec_key_we  = 1'b0;
    dec_val_we  = 1'b0;
    dec_rank_we = 1'b0;
    dec_alloc   = 1'b0;
    if (hit_q) begin
      dec_res.found = 1'b1;
      dec_old       = OccW'(hit_rank_q);
      dec_rank_we   = 1'b1;
      if (req_q.mode == ModeGet) begin
        dec_res.read_value = hit_val_q;
      end else begin
        dec_val_we = 1'b1;
      end
    end else if (req_q.mode == ModePut) begin
      dec_key_we  = 1'b1;
      dec_val_we  = 1'b1;
      dec_rank_we = 1'b1;
      if (occ_q < cap_q) begin
        dec_tgt   = free_idx_q;
        dec_old   = occ_q + OccW'(1);
        dec_alloc = 1'b1;
      end else begin
        dec_tgt             = lru_idx_q;
        dec_old             = OccW'(lru_rank_q);
        dec_res.evicted     = 1'b1;
        dec_res.evicted_key = lru_key_q;
      end
    end
  end

  always_comb begin
    if (cmd_i.decide) begin
      rank_we = dec_rank_we;
      rank_wa = dec_tgt;
      rank_wd = '0;
    end else begin
      rank_we = upd_we;
      rank_wa = rd_idx_q;
      rank_wd = rd_rank_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && dec_key_we) begin
      key_mem[dec_tgt] <= req_q.key;
    end
    if (cmd_i.decide && dec_val_we) begin
      val_mem[dec_tgt] <= req_q.value;
    end
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    if (cmd_i.issue) begin
      rd_key_q  <= key_mem[scan_q];
      rd_val_q  <= val_mem[scan_q];
      rd_rank_q <= rank_mem[scan_q];
      rd_vld_q  <= valid_q[scan_q];
      rd_idx_q  <= scan_q;
    end
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.decide) begin
      tgt_q <= dec_tgt;
      old_q <= dec_old;
      res_q <= dec_res;
    end
    if (cmd_i.finish) begin
      out_q <= res_q;
    end
    if (is_hit) begin
      hit_idx_q  <= rd_idx_q;
      hit_rank_q <= rd_rank_q;
      hit_val_q  <= rd_val_q;
    end
    if (is_free) begin
      free_idx_q <= rd_idx_q;
    end
    if (is_lru) begin
      lru_idx_q  <= rd_idx_q;
      lru_rank_q <= rd_rank_q;
      lru_key_q  <= rd_key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      occ_q       <= '0;
      cap_q       <= clamp_cap(CfgW'(ENTRIES));
      scan_q      <= '0;
      rd_live_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      lru_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_live_q <= cmd_i.issue;
      if (cfg_we_i && (occ_q == '0)) begin
        cap_q <= clamp_cap(cfg_wdata_i);
      end
      if (cmd_i.load) begin
        scan_q <= '0;
      end else if (cmd_i.issue) begin
        scan_q <= sts_o.scan_last ? '0 : scan_q + IdxW'(1);
      end
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        lru_q  <= 1'b0;
      end else begin
        if (is_hit) begin
          hit_q <= 1'b1;
        end
        if (is_free) begin
          free_q <= 1'b1;
        end
        if (is_lru) begin
          lru_q <= 1'b1;
        end
      end
      if (cmd_i.decide && dec_alloc) begin
        valid_q[dec_tgt] <= 1'b1;
        occ_q            <= occ_q + OccW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/lrukv_checker.sv
// ----------------------------------------------------------------------------
// LRU key/value cache checker
// Port-level assertions on transactions and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrukv_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input lrukv_pkg::out_t            out_data_o
);
  import lrukv_pkg::*;

  logic in_acc;
  logic out_stall;
  logic out_miss;
  logic out_no_ev;
  logic out_hit_ev;

  assign in_acc     = in_valid_i && in_ready_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign out_miss   = out_valid_o && !out_data_o.found;
  assign out_no_ev  = out_valid_o && !out_data_o.evicted;
  assign out_hit_ev = out_valid_o && out_data_o.found && out_data_o.evicted;

  `LRUKV_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_data_o))
  `LRUKV_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_acc |=> !in_ready_o)
  `LRUKV_NEVER(a_hit_and_evict, clk_i, rst_ni, out_hit_ev)
  `LRUKV_ASSERT(a_no_evict_key, clk_i, rst_ni, out_no_ev |-> (out_data_o.evicted_key == '0))
  `LRUKV_ASSERT(a_miss_zero, clk_i, rst_ni, out_miss |-> (out_data_o.read_value == '0))

endmodule

bind lru_key_value_cache_unit lrukv_checker u_lrukv_checker (.*);
